@@ hdl/swrl_pkg.sv @@
// ----------------------------------------------------------------------------
// Sliding window rate limiter package
// Shared widths, register indexes, reset values and the command and status
// bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package swrl_pkg;

    // Default sizing of the key table and of each key's timestamp ring.
    localparam int DEF_NUM_KEYS  = 64;
    localparam int DEF_MAX_LIMIT = 16;

    // Fixed field widths.
    localparam int KEY_ID_W    = 6;
    localparam int STAMP_W     = 48;
    localparam int LIMIT_W     = 5;
    localparam int WINDOW_W    = 32;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 32;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_REQUEST_LIMIT = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LENGTH = 1'd1;

    // Configuration reset values.
    localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 5'd16;
    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 32'd1000;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_step;   // zero one entry of the key table
        logic accept;       // take a request with a valid key
        logic reject;       // answer a request with an out-of-range key
        logic load_meta;    // load head and count of the current key
        logic pop;          // drop the oldest stamp of the ring
        logic decide;       // allow or reject, append and write back
    } swrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;   // the clearing pass is at its last entry
        logic key_ok;       // the offered key is inside the table
        logic pop_ok;       // the ring is not empty and its oldest stamp expired
    } swrl_status_t;

endpackage

@@ hdl/swrl_ctrl.sv @@
// ----------------------------------------------------------------------------
// Sliding window rate limiter controller
// Sequences the clearing pass after reset, the key table look-up, the expiry
// scan over the ring and the final decision for each request.
// ----------------------------------------------------------------------------
module swrl_ctrl
    import swrl_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  swrl_status_t status,
    output swrl_cmd_t    cmd,
    output logic         busy
);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_META   = 3'd2;
    localparam logic [2:0] ST_SCAN   = 3'd3;
    localparam logic [2:0] ST_DECIDE = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    if (status.key_ok)
                    begin
                        cmd.accept = 1'b1;
                        state_next = ST_META;
                    end
                    else
                    begin
                        cmd.reject = 1'b1;
                    end
                end
            end
            ST_META:
            begin
                cmd.load_meta = 1'b1;
                state_next    = ST_SCAN;
            end
            ST_SCAN:
            begin
                // One expired stamp leaves the ring in each cycle.
                if (status.pop_ok)
                begin
                    cmd.pop = 1'b1;
                end
                else
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

@@ hdl/swrl_datapath.sv @@
// ----------------------------------------------------------------------------
// Sliding window rate limiter datapath
// Holds the configuration, the per-key head and count table, the timestamp
// store, the expiry compare and the registered result.
// ----------------------------------------------------------------------------
module swrl_datapath
    import swrl_pkg::*;
#(
    parameter int NUM_KEYS  = DEF_NUM_KEYS,
    parameter int MAX_LIMIT = DEF_MAX_LIMIT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic [KEY_ID_W-1:0]    key_id,
    input  logic [STAMP_W-1:0]     req_time,
    input  swrl_cmd_t              cmd,
    output swrl_status_t           status,
    output logic                   done,
    output logic                   allowed
);

    localparam int KEY_W   = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int HEAD_W  = (MAX_LIMIT > 1) ? $clog2(MAX_LIMIT) : 1;
    localparam int COUNT_W = $clog2(MAX_LIMIT + 1);
    localparam int META_W  = HEAD_W + COUNT_W;
    localparam int SUM_W   = HEAD_W + 1;
    localparam int ADDR_W  = (NUM_KEYS * MAX_LIMIT > 1) ? $clog2(NUM_KEYS * MAX_LIMIT) : 1;
    localparam int SLOTS   = NUM_KEYS * MAX_LIMIT;
    localparam int LC_W    = (COUNT_W > LIMIT_W) ? COUNT_W : LIMIT_W;
    localparam int KCMP_W  = 14;

    // Configuration registers.
    logic [LIMIT_W-1:0]  limit_reg;
    logic [WINDOW_W-1:0] window_reg;

    // Request registers and ring pointers of the current key.
    logic [KEY_W-1:0]    key_reg;
    logic [STAMP_W-1:0]  now_reg;
    logic [HEAD_W-1:0]   head_reg;
    logic [HEAD_W-1:0]   head_next;
    logic [COUNT_W-1:0]  count_reg;
    logic [COUNT_W-1:0]  count_next;
    logic [KEY_W-1:0]    clr_addr_reg;

    // Memories and their registered read data.
    logic [META_W-1:0]   meta_mem [NUM_KEYS];
    logic [META_W-1:0]   meta_rd_reg;
    logic [STAMP_W-1:0]  stamp_mem [SLOTS];
    logic [STAMP_W-1:0]  stamp_rd_reg;

    // Result registers.
    logic                done_reg;
    logic                allowed_reg;

    logic                meta_we;
    logic [KEY_W-1:0]    meta_waddr;
    logic [META_W-1:0]   meta_wdata;
    logic [ADDR_W-1:0]   stamp_raddr;
    logic [ADDR_W-1:0]   stamp_waddr;
    logic [SUM_W-1:0]    tail_sum;
    logic [HEAD_W-1:0]   tail_idx;
    logic [HEAD_W-1:0]   head_inc;
    logic [STAMP_W:0]    expiry_sum;
    logic                expired;
    logic                room;
    logic                stamp_we;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg  <= LIMIT_RESET;
            window_reg <= WINDOW_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_REQUEST_LIMIT: limit_reg  <= cfg_data[LIMIT_W-1:0];
                REG_WINDOW_LENGTH: window_reg <= cfg_data[WINDOW_W-1:0];
                default:           ;
            endcase
        end
    end

    // Key range check on the offered request.
    assign status.key_ok = (KCMP_W'(key_id) < KCMP_W'(NUM_KEYS));

    // Clearing pass over the key table.
    assign status.clear_last = (clr_addr_reg == KEY_W'(NUM_KEYS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clear_step)
        begin
            clr_addr_reg <= clr_addr_reg + KEY_W'(1);
        end
    end

    // Ring pointer updates: load from the table, then advance on each pop.
    assign head_inc = (head_reg == HEAD_W'(MAX_LIMIT - 1)) ? '0 : head_reg + HEAD_W'(1);

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        priority if (cmd.load_meta)
        begin
            head_next  = meta_rd_reg[META_W-1:COUNT_W];
            count_next = meta_rd_reg[COUNT_W-1:0];
        end
        else if (cmd.pop)
        begin
            head_next  = head_inc;
            count_next = count_reg - COUNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg  <= head_next;
        count_reg <= count_next;
        if (cmd.accept)
        begin
            key_reg <= KEY_W'(key_id);
            now_reg <= req_time;
        end
    end

    // Expiry test on the oldest stamp: stamp plus window at or before now.
    assign expiry_sum    = {1'b0, stamp_rd_reg} + (STAMP_W + 1)'(window_reg);
    assign expired       = (expiry_sum <= {1'b0, now_reg});
    assign status.pop_ok = (count_reg != '0) && expired;

    // Room left in the ring under the configured and the built-in limit.
    assign room = (LC_W'(count_reg) < LC_W'(limit_reg))
               && (count_reg < COUNT_W'(MAX_LIMIT));

    // Slot that follows the newest stamp of the ring.
    assign tail_sum = SUM_W'(head_reg) + SUM_W'(count_reg);
    assign tail_idx = (tail_sum >= SUM_W'(MAX_LIMIT))
                    ? HEAD_W'(tail_sum - SUM_W'(MAX_LIMIT))
                    : HEAD_W'(tail_sum);

    // Timestamp store addresses: the read follows the head of the next cycle.
    assign stamp_raddr = ADDR_W'(key_reg) * ADDR_W'(MAX_LIMIT) + ADDR_W'(head_next);
    assign stamp_waddr = ADDR_W'(key_reg) * ADDR_W'(MAX_LIMIT) + ADDR_W'(tail_idx);
    assign stamp_we    = cmd.decide && room;

    always_ff @(posedge clk)
    begin
        if (stamp_we)
        begin
            stamp_mem[stamp_waddr] <= now_reg;
        end
        stamp_rd_reg <= stamp_mem[stamp_raddr];
    end

    // Key table: cleared after reset, read on a transfer, written back at the decision.
    always_comb
    begin
        meta_we    = cmd.clear_step || cmd.decide;
        meta_waddr = key_reg;
        meta_wdata = {head_reg, room ? count_reg + COUNT_W'(1) : count_reg};
        if (cmd.clear_step)
        begin
            meta_waddr = clr_addr_reg;
            meta_wdata = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (meta_we)
        begin
            meta_mem[meta_waddr] <= meta_wdata;
        end
        if (cmd.accept)
        begin
            meta_rd_reg <= meta_mem[KEY_W'(key_id)];
        end
    end

    // Result strobe and flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.decide || cmd.reject;
        end
    end

    always_ff @(posedge clk)
    begin
        allowed_reg <= cmd.decide && room;
    end

    assign done    = done_reg;
    assign allowed = allowed_reg;

endmodule

@@ hdl/sliding_window_rate_limiter.sv @@
// ----------------------------------------------------------------------------
// Sliding window rate limiter
// Per-key sliding-log rate limiter with one ring of accepted timestamps per key.
// ----------------------------------------------------------------------------
// A request is taken at a clock edge where start is high and busy is low; its
// single result appears on done and allowed in the cycle after the decision, for
// exactly one cycle, and the receiver cannot stall it. A request with a key in
// range keeps busy high through the look-up, the expiry scan that drops each
// expired stamp from that key's ring, and the decision: the expiry scan reads one stamp per
// cycle from the single read port of the timestamp store. A key outside the
// table is answered with allowed low in the cycle after without raising busy.
// After reset the key table is cleared one entry per cycle, with busy high until
// every entry is cleared and only then is the first request taken; configuration
// writes are taken at any time.
module sliding_window_rate_limiter
    import swrl_pkg::*;
#(
    parameter int NUM_KEYS  = DEF_NUM_KEYS,
    parameter int MAX_LIMIT = DEF_MAX_LIMIT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   start,
    output logic                   busy,
    input  logic [KEY_ID_W-1:0]    key_id,
    input  logic [STAMP_W-1:0]     req_time,
    output logic                   done,
    output logic                   allowed
);

    swrl_cmd_t    cmd;
    swrl_status_t status;

    // Controller.
    swrl_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // Datapath.
    swrl_datapath
    #(
        .NUM_KEYS  (NUM_KEYS),
        .MAX_LIMIT (MAX_LIMIT)
    )
    u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .key_id       (key_id),
        .req_time     (req_time),
        .cmd          (cmd),
        .status       (status),
        .done         (done),
        .allowed      (allowed)
    );

endmodule

@@ bench/sliding_window_rate_limiter_test.sv @@
// ----------------------------------------------------------------------------
// Sliding window rate limiter testbench
// Drives timestamped requests into the limiter and checks every allow flag.
// A stimulus table opens the run with the reset state, field extremes, a full
// ring, a zero limit, a limit above capacity, zero and maximal windows and
// out-of-order stamps. Randomised phases follow, each with its own register
// setting and sender idling. In these phases a few busy keys fill their rings
// at a pace matched to the window. Each result is compared with a behavioural
// model of the per-key timestamp rings that runs inside this bench.
// ----------------------------------------------------------------------------
module sliding_window_rate_limiter_test;

    timeunit 1ns;
    timeprecision 1ps;

    import swrl_pkg::*;

    localparam int NUM_KEYS       = DEF_NUM_KEYS;
    localparam int MAX_LIMIT      = DEF_MAX_LIMIT;
    // The settle wait outlasts the longest busy stretch, a full expiry scan included.
    localparam int SETTLE_CYCLES  = MAX_LIMIT + 8;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_ITEMS    = 200;

    localparam logic [STAMP_W-1:0] STAMP_MAX = {STAMP_W{1'b1}};

    // Kinds of row in the opening stimulus table.
    typedef enum logic [1:0] {
        ROW_REQUEST,
        ROW_SET_LIMIT,
        ROW_SET_WINDOW
    } row_kind_t;

    // Where the expected allow flag of a request comes from.
    typedef enum logic [1:0] {
        VERDICT_MODEL,
        VERDICT_DENY,
        VERDICT_GRANT
    } verdict_t;

    typedef struct packed {
        row_kind_t            kind;
        logic [KEY_ID_W-1:0]  key;
        logic [STAMP_W-1:0]   value;
        int                   reps;
        verdict_t             verdict;
    } plan_row_t;

    // Opening table: requests, and register writes made while idle.
    plan_row_t opening_plan [20] = '{
        '{ROW_REQUEST,    6'd0,  48'd0,             1, VERDICT_GRANT},
        '{ROW_REQUEST,    6'd63, STAMP_MAX,         1, VERDICT_GRANT},
        '{ROW_REQUEST,    6'd63, 48'd0,             1, VERDICT_MODEL},
        '{ROW_REQUEST,    6'd42, 48'hAAAA_AAAA_AAAA, 1, VERDICT_MODEL},
        '{ROW_REQUEST,    6'd21, 48'h5555_5555_5555, 1, VERDICT_MODEL},
        '{ROW_SET_LIMIT,  6'd0,  48'd2,             1, VERDICT_MODEL},
        '{ROW_REQUEST,    6'd5,  48'd100,           2, VERDICT_MODEL},
        '{ROW_REQUEST,    6'd5,  48'd1099,          1, VERDICT_DENY},
        '{ROW_REQUEST,    6'd5,  48'd1100,          1, VERDICT_MODEL},
        '{ROW_SET_LIMIT,  6'd0,  48'd0,             1, VERDICT_MODEL},
        '{ROW_REQUEST,    6'd5,  48'd5000,          1, VERDICT_DENY},
        '{ROW_SET_WINDOW, 6'd0,  48'd0,             1, VERDICT_MODEL},
        '{ROW_SET_LIMIT,  6'd0,  48'd31,            1, VERDICT_MODEL},
        '{ROW_REQUEST,    6'd6,  48'd77,            2, VERDICT_MODEL},
        '{ROW_REQUEST,    6'd6,  48'd76,            1, VERDICT_MODEL},
        '{ROW_SET_WINDOW, 6'd0,  48'hFFFF_FFFF,     1, VERDICT_MODEL},
        '{ROW_REQUEST,    6'd7,  STAMP_MAX,         1, VERDICT_MODEL},
        '{ROW_REQUEST,    6'd7,  48'd0,             1, VERDICT_MODEL},
        '{ROW_SET_LIMIT,  6'd0,  48'd1,             1, VERDICT_MODEL},
        '{ROW_REQUEST,    6'd8,  48'd10,            2, VERDICT_MODEL}
    };

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   start;
    logic                   busy;
    logic [KEY_ID_W-1:0]    key_id;
    logic [STAMP_W-1:0]     req_time;
    logic                   done;
    logic                   allowed;

    // Model of the limiter: register copies and one timestamp ring per key.
    logic [LIMIT_W-1:0]  limit_copy;
    logic [WINDOW_W-1:0] window_copy;
    logic [STAMP_W-1:0]  ring_stamp [NUM_KEYS][MAX_LIMIT];
    int unsigned         ring_oldest [NUM_KEYS];
    int unsigned         ring_fill [NUM_KEYS];

    logic     expected_allow [$];
    verdict_t typed_verdict;
    int       sender_idle_pct;
    int       error_count;
    int       requests_taken;
    int       grants_seen;
    int       settings_used;
    int       quiet_cycles;

    sliding_window_rate_limiter dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .start        (start),
        .busy         (busy),
        .key_id       (key_id),
        .req_time     (req_time),
        .done         (done),
        .allowed      (allowed)
    );

    // Clock with a 4 ns period.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [63:0] random_word64();
        return {$urandom, $urandom};
    endfunction

    // Drop expired stamps of the key, then grant and log if the ring has room.
    function automatic logic judge_request(input logic [KEY_ID_W-1:0] key,
                                           input logic [STAMP_W-1:0] now);
        int unsigned  cap;
        int unsigned  slot;
        logic [STAMP_W:0] expiry;
        if (key >= NUM_KEYS)
            return 1'b0;
        while (ring_fill[key] != 0)
        begin
            expiry = {1'b0, ring_stamp[key][ring_oldest[key]]} + {17'd0, window_copy};
            if (expiry > {1'b0, now})
                break;
            ring_oldest[key] = (ring_oldest[key] + 1) % MAX_LIMIT;
            ring_fill[key]   = ring_fill[key] - 1;
        end
        cap = (limit_copy > MAX_LIMIT) ? MAX_LIMIT : limit_copy;
        if (ring_fill[key] >= cap)
            return 1'b0;
        slot = (ring_oldest[key] + ring_fill[key]) % MAX_LIMIT;
        ring_stamp[key][slot] = now;
        ring_fill[key] = ring_fill[key] + 1;
        return 1'b1;
    endfunction

    // Result checking and request prediction, both on the rising edge.
    always @(posedge clk)
    begin
        logic predicted;
        logic wanted;
        logic queued;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_allow.size() == 0)
                begin
                    $error("allowed: result with no request outstanding, got %0b", allowed);
                    error_count++;
                end
                else
                begin
                    wanted = expected_allow[0];
                    expected_allow.delete(0);
                    if (allowed !== wanted)
                    begin
                        $error("allowed: expected %0b, got %0b", wanted, allowed);
                        error_count++;
                    end
                end
                if (allowed === 1'b1)
                    grants_seen++;
            end
            if (start && !busy)
            begin
                predicted = judge_request(key_id, req_time);
                case (typed_verdict)
                    VERDICT_DENY:  queued = 1'b0;
                    VERDICT_GRANT: queued = 1'b1;
                    default:       queued = predicted;
                endcase
                expected_allow.insert(expected_allow.size(), queued);
                requests_taken++;
            end
        end
    end

    // Watchdog: ends the run after too long without any transfer.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog expired with %0d results outstanding.", expected_allow.size());
            $display("sliding_window_rate_limiter_test: done, errors");
            $finish;
        end
    end

    // Offer one request, with random idle cycles first, and wait for its transfer.
    task automatic issue(input logic [KEY_ID_W-1:0] key, input logic [STAMP_W-1:0] stamp,
                         input verdict_t verdict);
        @(negedge clk);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start         <= 1'b1;
        key_id        <= key;
        req_time      <= stamp;
        typed_verdict = verdict;
        // Busy only moves on a rising edge, so it is steady at a falling edge.
        while (busy)
            @(negedge clk);
        @(posedge clk);
    endtask

    // Stop sending and wait until every outstanding result has arrived.
    task automatic drain_results(input bit settle);
        @(negedge clk);
        start <= 1'b0;
        while (expected_allow.size() != 0)
            @(negedge clk);
        if (settle)
            repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
        if (index == REG_REQUEST_LIMIT)
            limit_copy = data[LIMIT_W-1:0];
        else if (index == REG_WINDOW_LENGTH)
            window_copy = data;
        settings_used++;
    endtask

    // One random phase: a few busy keys paced against the window, plus noise.
    task automatic run_phase(input logic [CFG_DATA_W-1:0] limit_data,
                             input logic [CFG_DATA_W-1:0] window_data, input int idle_pct);
        logic [63:0]         step;
        logic [63:0]         cap;
        logic [STAMP_W-1:0]  now;
        logic [STAMP_W-1:0]  stamp;
        logic [KEY_ID_W-1:0] key_base;
        logic [KEY_ID_W-1:0] key;
        int                  roll;
        drain_results(1'b1);
        write_register(REG_REQUEST_LIMIT, limit_data);
        write_register(REG_WINDOW_LENGTH, window_data);
        sender_idle_pct = idle_pct;
        cap = (limit_copy > MAX_LIMIT) ? 64'(MAX_LIMIT)
                                       : ((limit_copy == 0) ? 64'd1 : 64'(limit_copy));
        step = {32'd0, window_copy} / (64'd4 * cap);
        if (step == 0)
            step = 1;
        now      = STAMP_W'(random_word64());
        key_base = KEY_ID_W'($urandom_range(0, NUM_KEYS - 1));
        for (int n = 0; n < PHASE_ITEMS; n++)
        begin
            // Halfway through, let the block run dry before carrying on.
            if (n == PHASE_ITEMS / 2)
                drain_results(1'b0);
            if ($urandom_range(0, 99) < 80)
                key = key_base + KEY_ID_W'($urandom_range(0, 3));
            else
                key = KEY_ID_W'($urandom_range(0, NUM_KEYS - 1));
            roll = $urandom_range(0, 99);
            if (roll < 80)
            begin
                now   = now + STAMP_W'(random_word64() % (step + 1));
                stamp = now;
            end
            else if (roll < 90)
                stamp = now - STAMP_W'(random_word64() % (step + 1));
            else
                stamp = STAMP_W'(random_word64());
            issue(key, stamp, VERDICT_MODEL);
        end
    endtask

    initial
    begin
        cfg_write       = 1'b0;
        cfg_index       = REG_REQUEST_LIMIT;
        cfg_data        = '0;
        start           = 1'b0;
        key_id          = '0;
        req_time        = '0;
        rst_n           = 1'b0;
        typed_verdict   = VERDICT_MODEL;
        sender_idle_pct = 0;
        error_count     = 0;
        requests_taken  = 0;
        grants_seen     = 0;
        settings_used   = 0;
        quiet_cycles    = 0;
        limit_copy      = LIMIT_RESET;
        window_copy     = WINDOW_RESET;
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            ring_oldest[k] = 0;
            ring_fill[k]   = 0;
        end

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Opening table.
        foreach (opening_plan[r])
        begin
            case (opening_plan[r].kind)
                ROW_SET_LIMIT:
                begin
                    drain_results(1'b1);
                    write_register(REG_REQUEST_LIMIT, opening_plan[r].value[CFG_DATA_W-1:0]);
                end
                ROW_SET_WINDOW:
                begin
                    drain_results(1'b1);
                    write_register(REG_WINDOW_LENGTH, opening_plan[r].value[CFG_DATA_W-1:0]);
                end
                default:
                    repeat (opening_plan[r].reps)
                        issue(opening_plan[r].key, opening_plan[r].value,
                              opening_plan[r].verdict);
            endcase
        end

        // Random phases: reset values, extremes, zero limit and random settings.
        run_phase(32'd16, 32'd1000, 0);
        run_phase(32'd1, 32'd0, 78);
        run_phase(32'd31, 32'hFFFF_FFFF, 0);
        run_phase(32'd0, 32'd500, 37);
        run_phase(32'd4, 32'd50, 0);
        run_phase(($urandom & 32'hFFFF_FFE0) | $urandom_range(1, 16),
                  $urandom_range(1, 100000), 78);
        run_phase(32'd2, 32'd1, 37);
        run_phase(32'd17, $urandom_range(1, 5000), 0);

        drain_results(1'b1);
        if (expected_allow.size() != 0)
        begin
            $error("allowed: %0d results never arrived", expected_allow.size());
            error_count++;
        end

        $display("Covered %0d requests, %0d granted, across %0d register writes.",
                 requests_taken, grants_seen, settings_used);
        $display("Settings ranged over zero and over-capacity limits, zero to maximal windows.");
        if (error_count == 0)
            $display("sliding_window_rate_limiter_test: done, clean");
        else
            $display("sliding_window_rate_limiter_test: done, errors");
        $finish;
    end

endmodule

@@ files.f @@
hdl/swrl_pkg.sv
hdl/swrl_ctrl.sv
hdl/swrl_datapath.sv
hdl/sliding_window_rate_limiter.sv
bench/sliding_window_rate_limiter_test.sv
